>>> rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Types and constants for the thermostat frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

  localparam int FRAME_LEN = 16;
  localparam int FRAME_AW  = $clog2(FRAME_LEN);

  // Field positions inside a command frame
  localparam int POS_HDR  = 0;
  localparam int POS_MODE = 1;
  localparam int POS_LO   = 3;
  localparam int POS_UP   = 7;
  localparam int POS_FCMD = 10;
  localparam int POS_FAN  = 11;
  localparam int POS_LAMP = 14;

  localparam logic [7:0] CH_AT = 8'h40;  // '@'
  localparam logic [7:0] CH_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_M  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_S  = 8'h53;  // 'S'
  localparam logic [7:0] CH_F  = 8'h46;  // 'F'
  localparam logic [7:0] CH_X  = 8'h58;  // 'X'
  localparam logic [7:0] CH_B  = 8'h42;  // 'B'

  localparam logic [15:0] DIGIT_BASE = 16'd48;
  localparam logic [7:0]  DUTY_RESET = 8'd200;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_COLD   = 2'd1;
  localparam logic [1:0] ST_HOT    = 2'd2;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [9:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic [1:0] resp_code;
    logic [7:0] fan_duty;
    logic       lamp_on;
    logic [1:0] temp_state;
    logic       last;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/thermostat_frame_controller.sv
// ----------------------------------------------------------------------------
// thermostat_frame_controller
// Serial command frame collector with a two-threshold temperature controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall) carry either a serial byte (func 0) or a
//   temperature sample (func 1). Every 16th byte completes a frame, which is
//   decoded in the cycle it is taken. Samples rerun the auto or manual check.
//   Result words (out_valid/out_stall) carry the response code, fan duty,
//   lamp, status and a last flag closing the responses of one input word.
//   One input word is taken per cycle while in_stall is low. Its first result
//   is offered the cycle after it is taken; a word with two responses delivers
//   the second one once the first has been popped. The flow is bounded by the
//   4-entry result queue: in_stall rises while fewer than two queue entries
//   are free, so a stalled receiver backs up into the input within three words.
//   The cfg port writes the auto-mode fan duty and is always ready.
//   Synchronous reset clears the frame, limits, actuators, the queue, and
//   loads the auto fan duty with 200.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_frame_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tfc_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tfc_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0]                  auto_fan_duty;
  logic [7:0]                  frame_store [tfc_pkg::FRAME_LEN];
  logic [tfc_pkg::FRAME_AW-1:0] byte_pos;
  logic [15:0]                 lower_limit;
  logic [15:0]                 upper_limit;
  logic [9:0]                  cur_temp;
  logic [7:0]                  duty_reg;
  logic                        lamp_reg;
  logic [1:0]                  status_reg;

  tfc_pkg::out_word_t           queue [tfc_pkg::QUEUE_DEPTH];
  logic [tfc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [tfc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [tfc_pkg::QUEUE_CW-1:0] count;

  logic        accept;
  logic        pop;
  logic        is_sample;
  logic        frame_done;
  logic        hdr_ok;
  logic [7:0]  mode;
  logic        auto_run;
  logic        man_frame;
  logic        stat_frame;
  logic        man_sample;
  logic        reparse;
  logic        respond;
  logic        push_two;
  logic [15:0] lo_p;
  logic [15:0] up_p;
  logic [15:0] fan_p;
  logic [15:0] lim_lo;
  logic [15:0] lim_up;
  logic [9:0]  temp_eff;
  logic        hot;
  logic        cold;
  logic [1:0]  code0;
  logic [7:0]  duty_next;
  logic        lamp_next;
  logic [1:0]  status_next;
  logic [1:0]  push_n;
  logic [tfc_pkg::QUEUE_CW-1:0] count_next;
  tfc_pkg::out_word_t           word0;
  tfc_pkg::out_word_t           word1;

  function automatic logic [15:0] times10(input logic [15:0] x);
    times10 = (x << 3) + (x << 1);
  endfunction

  function automatic logic [15:0] parse3(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2);
    logic [15:0] d0;
    logic [15:0] d1;
    logic [15:0] d2;
    d0 = {8'd0, b0} - tfc_pkg::DIGIT_BASE;
    d1 = {8'd0, b1} - tfc_pkg::DIGIT_BASE;
    d2 = {8'd0, b2} - tfc_pkg::DIGIT_BASE;
    parse3 = times10(times10(d0) + d1) + d2;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > tfc_pkg::QUEUE_CW'(tfc_pkg::QUEUE_DEPTH - 2));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    is_sample  = in_data.func;
    frame_done = !in_data.func &&
                 (byte_pos == tfc_pkg::FRAME_AW'(tfc_pkg::FRAME_LEN - 1));
    hdr_ok     = (frame_store[tfc_pkg::POS_HDR] == tfc_pkg::CH_AT);
    mode       = frame_store[tfc_pkg::POS_MODE];

    lo_p  = parse3(frame_store[tfc_pkg::POS_LO], frame_store[tfc_pkg::POS_LO + 1],
                   frame_store[tfc_pkg::POS_LO + 2]);
    up_p  = parse3(frame_store[tfc_pkg::POS_UP], frame_store[tfc_pkg::POS_UP + 1],
                   frame_store[tfc_pkg::POS_UP + 2]);
    fan_p = parse3(frame_store[tfc_pkg::POS_FAN], frame_store[tfc_pkg::POS_FAN + 1],
                   frame_store[tfc_pkg::POS_FAN + 2]);

    auto_run   = accept && (mode == tfc_pkg::CH_A) && (is_sample || (frame_done && hdr_ok));
    man_frame  = accept && frame_done && hdr_ok && (mode == tfc_pkg::CH_M);
    stat_frame = accept && frame_done && hdr_ok && (mode == tfc_pkg::CH_S);
    man_sample = accept && is_sample && (mode == tfc_pkg::CH_M);
    reparse    = auto_run || man_frame;
    respond    = auto_run || man_frame || stat_frame || man_sample;

    lim_lo   = reparse ? lo_p : lower_limit;
    lim_up   = reparse ? up_p : upper_limit;
    temp_eff = is_sample ? in_data.temperature : cur_temp;
    hot      = ({6'd0, temp_eff} > lim_up);
    cold     = ({6'd0, temp_eff} < lim_lo);

    // auto runs (sample or frame) and manual samples report both tests; manual and status frames report one
    push_two = (auto_run || man_sample) && hot && cold;
    code0    = hot ? tfc_pkg::ST_HOT : (cold ? tfc_pkg::ST_COLD : tfc_pkg::ST_NORMAL);

    duty_next = duty_reg;
    lamp_next = lamp_reg;
    if (auto_run) begin
      duty_next = (hot && !cold) ? auto_fan_duty : 8'd0;
      lamp_next = cold;
    end else if (man_frame) begin
      if (frame_store[tfc_pkg::POS_FCMD] == tfc_pkg::CH_F) begin
        duty_next = fan_p[7:0];
      end else if (frame_store[tfc_pkg::POS_FCMD] == tfc_pkg::CH_X) begin
        duty_next = 8'd0;
      end
      lamp_next = (frame_store[tfc_pkg::POS_LAMP] == tfc_pkg::CH_B);
    end

    status_next = status_reg;
    if (respond) begin
      status_next = push_two ? tfc_pkg::ST_COLD : code0;
    end

    word0.resp_code  = code0;
    word0.fan_duty   = duty_next;
    word0.lamp_on    = lamp_next;
    word0.temp_state = status_next;
    word0.last       = !push_two;

    word1.resp_code  = tfc_pkg::ST_COLD;
    word1.fan_duty   = duty_next;
    word1.lamp_on    = lamp_next;
    word1.temp_state = status_next;
    word1.last       = 1'b1;

    push_n     = respond ? (push_two ? 2'd2 : 2'd1) : 2'd0;
    count_next = count + tfc_pkg::QUEUE_CW'(push_n) - tfc_pkg::QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_fan_duty <= tfc_pkg::DUTY_RESET;
      for (int i = 0; i < tfc_pkg::FRAME_LEN; i++) begin
        frame_store[i] <= 8'd0;
      end
      byte_pos    <= '0;
      lower_limit <= 16'd0;
      upper_limit <= 16'd0;
      cur_temp    <= 10'd0;
      duty_reg    <= 8'd0;
      lamp_reg    <= 1'b0;
      status_reg  <= tfc_pkg::ST_NORMAL;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      count       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        auto_fan_duty <= cfg_data;
      end
      if (accept && !is_sample) begin
        frame_store[byte_pos] <= in_data.rx_byte;
        byte_pos              <= byte_pos + 1'b1;
      end
      if (accept && is_sample) begin
        cur_temp <= in_data.temperature;
      end
      if (reparse) begin
        lower_limit <= lo_p;
        upper_limit <= up_p;
      end
      duty_reg   <= duty_next;
      lamp_reg   <= lamp_next;
      status_reg <= status_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr + push_n[tfc_pkg::QUEUE_AW-1:0];
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= word0;
    end
    if (push_two) begin
      queue[wr_ptr + 1'b1] <= word1;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tfc_pkg::QUEUE_CW'(tfc_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_byte_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_data.func) |=> (byte_pos == $past(byte_pos) + 1'b1))
    else $error("byte position did not advance");

  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.func) |=> (cur_temp == $past(in_data.temperature)))
    else $error("sample not captured");

  a_two_fit: assert property (@(posedge clk) disable iff (rst)
    push_two |-> (count <= tfc_pkg::QUEUE_CW'(tfc_pkg::QUEUE_DEPTH - 2)))
    else $error("two results pushed without room");

endmodule

`default_nettype wire

>>> sim/tfc_response_checker.sv
// ----------------------------------------------------------------------------
// tfc_response_checker
// Watches the input, result and cfg channels of the thermostat frame
// controller. It keeps its own frame buffer, limits and actuator state and
// works out the responses of every accepted input word. Each accepted result
// word is compared with the oldest expected one, and mismatches are counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfc_response_checker
  import tfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_word_t out_data,
  input  wire logic      cfg_valid,
  input  wire logic      cfg_ready,
  input  wire logic [7:0] cfg_data,
  output int             fail_count,
  output int             pending
);

  logic [7:0]  frame_buf [FRAME_LEN];
  logic [3:0]  wr_pos;
  logic [15:0] lo_lim;
  logic [15:0] up_lim;
  logic [9:0]  temp_now;
  logic [7:0]  duty_now;
  logic        lamp_now;
  logic [1:0]  state_now;
  logic [7:0]  hot_duty;

  logic [1:0]  code_buf [2];
  int          code_cnt;

  out_word_t   expected_responses [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // three-digit field, 16-bit wrap, no digit check
  function automatic logic [15:0] field_value(input int start);
    logic [15:0] v;
    logic [15:0] d;
    v = '0;
    for (int k = 0; k < 3; k++) begin
      d = {8'h00, frame_buf[(start + k) % FRAME_LEN]} - DIGIT_BASE;
      v = v + d;
      if (k < 2) v = v * 16'd10;
    end
    return v;
  endfunction

  task automatic add_code(input logic [1:0] c);
    if (code_cnt < 2) begin
      code_buf[code_cnt] = c;
      code_cnt = code_cnt + 1;
    end
    state_now = c;
  endtask

  task automatic auto_eval();
    logic hot;
    logic cold;
    hot  = {6'd0, temp_now} > up_lim;
    cold = {6'd0, temp_now} < lo_lim;
    if (hot) begin
      duty_now = hot_duty;
      lamp_now = 1'b0;
      add_code(ST_HOT);
    end
    if (cold) begin
      duty_now = 8'd0;
      lamp_now = 1'b1;
      add_code(ST_COLD);
    end
    if (!hot && !cold) begin
      duty_now = 8'd0;
      lamp_now = 1'b0;
      add_code(ST_NORMAL);
    end
  endtask

  function automatic logic [1:0] one_code();
    if ({6'd0, temp_now} > up_lim) return ST_HOT;
    if ({6'd0, temp_now} < lo_lim) return ST_COLD;
    return ST_NORMAL;
  endfunction

  task automatic predict_responses(input in_word_t w);
    out_word_t r;
    code_cnt = 0;
    if (!w.func) begin
      frame_buf[wr_pos] = w.rx_byte;
      wr_pos = wr_pos + 4'd1;
      if (wr_pos == 4'd0 && frame_buf[POS_HDR] == CH_AT) begin
        if (frame_buf[POS_MODE] == CH_A) begin
          lo_lim = field_value(POS_LO);
          up_lim = field_value(POS_UP);
          auto_eval();
        end else if (frame_buf[POS_MODE] == CH_M) begin
          lo_lim = field_value(POS_LO);
          up_lim = field_value(POS_UP);
          add_code(one_code());
          if (frame_buf[POS_FCMD] == CH_F) begin
            duty_now = 8'(field_value(POS_FAN));
          end else if (frame_buf[POS_FCMD] == CH_X) begin
            duty_now = 8'd0;
          end
          lamp_now = (frame_buf[POS_LAMP] == CH_B);
        end else if (frame_buf[POS_MODE] == CH_S) begin
          add_code(one_code());
        end
      end
    end else begin
      temp_now = w.temperature;
      if (frame_buf[POS_MODE] == CH_A) begin
        lo_lim = field_value(POS_LO);
        up_lim = field_value(POS_UP);
        auto_eval();
      end else if (frame_buf[POS_MODE] == CH_M) begin
        if ({6'd0, temp_now} > up_lim) add_code(ST_HOT);
        if ({6'd0, temp_now} < lo_lim) add_code(ST_COLD);
        if ({6'd0, temp_now} <= up_lim && {6'd0, temp_now} >= lo_lim) add_code(ST_NORMAL);
      end
    end
    for (int k = 0; k < code_cnt; k++) begin
      r.resp_code  = code_buf[k];
      r.fan_duty   = duty_now;
      r.lamp_on    = lamp_now;
      r.temp_state = state_now;
      r.last       = (k == code_cnt - 1);
      expected_responses.push_back(r);
    end
  endtask

  task automatic check_response(input out_word_t got);
    out_word_t want;
    if (expected_responses.size() == 0) begin
      fail_count = fail_count + 1;
      if (fail_count <= 10)
        $display("unexpected result word: code %0d duty %0d lamp %0d state %0d last %0d",
                 got.resp_code, got.fan_duty, got.lamp_on, got.temp_state, got.last);
    end else begin
      want = expected_responses.pop_front();
      if (got !== want) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("mismatch (code duty lamp state last): exp %0d %0d %0d %0d %0d, %s",
                   want.resp_code, want.fan_duty, want.lamp_on, want.temp_state,
                   want.last,
                   $sformatf("got %0d %0d %0d %0d %0d", got.resp_code, got.fan_duty,
                             got.lamp_on, got.temp_state, got.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAME_LEN; k++) frame_buf[k] = 8'd0;
      wr_pos    = '0;
      lo_lim    = '0;
      up_lim    = '0;
      temp_now  = '0;
      duty_now  = '0;
      lamp_now  = 1'b0;
      state_now = ST_NORMAL;
      hot_duty  = DUTY_RESET;
      expected_responses.delete();
    end else begin
      if (cfg_valid && cfg_ready) hot_duty = cfg_data;
      if (in_valid && !in_stall) predict_responses(in_data);
      if (out_valid && !out_stall) check_response(out_data);
    end
    pending = expected_responses.size();
  end

endmodule

>>> sim/thermostat_frame_controller_tb.sv
// ----------------------------------------------------------------------------
// thermostat_frame_controller_tb
// Drives serial bytes and temperature samples into the thermostat frame
// controller: a few hand-built frames first, then phases of random frames,
// samples and stray bytes, with a new auto fan duty written before each phase.
// Both channels idle at random. Checking is done by tfc_response_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermostat_frame_controller_tb;
  import tfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 150;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  int        fail_count;
  int        pending;
  int        cycles;
  int        word_count;
  logic [3:0] byte_count;
  bit        calm;
  bit        garble;
  int        last_lo;
  int        last_up;

  thermostat_frame_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tfc_response_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cycles = 0;
    word_count = 0;
    byte_count = '0;
    calm = 1'b0;
    garble = 1'b0;
    last_lo = 0;
    last_up = 0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL thermostat_frame_controller");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    word_count = word_count + 1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_word_t w;
    w.func        = 1'b0;
    w.rx_byte     = b;
    w.temperature = 10'($urandom_range(1023));
    send_word(w);
    byte_count = byte_count + 4'd1;
  endtask

  task automatic send_sample(input int t);
    in_word_t w;
    w.func        = 1'b1;
    w.rx_byte     = 8'($urandom_range(255));
    w.temperature = 10'(t);
    send_word(w);
  endtask

  // digit k of a three-digit decimal field, sometimes replaced by junk
  function automatic logic [7:0] digit_byte(input int v, input int k);
    int div;
    div = (k == 0) ? 100 : (k == 1) ? 10 : 1;
    if (garble && $urandom_range(99) < 6) return 8'($urandom_range(255));
    return 8'(48 + ((v / div) % 10));
  endfunction

  task automatic send_frame(input logic [7:0] mode, input int lo, input int up,
                            input logic [7:0] fcmd, input int fan,
                            input logic [7:0] lamp, input bit hdr_ok);
    logic [7:0] f [FRAME_LEN];
    while (byte_count != 4'd0) send_byte(8'($urandom_range(255)));
    f[POS_HDR] = hdr_ok ? CH_AT : 8'($urandom_range(255));
    if (!hdr_ok && f[POS_HDR] == CH_AT) f[POS_HDR] = CH_AT ^ 8'h01;
    f[POS_MODE] = mode;
    f[2]  = 8'($urandom_range(255));
    f[6]  = 8'($urandom_range(255));
    f[15] = 8'($urandom_range(255));
    for (int k = 0; k < 3; k++) begin
      f[POS_LO + k]  = digit_byte(lo, k);
      f[POS_UP + k]  = digit_byte(up, k);
      f[POS_FAN + k] = digit_byte(fan, k);
    end
    f[POS_FCMD] = fcmd;
    f[POS_LAMP] = lamp;
    last_lo = lo;
    last_up = up;
    for (int k = 0; k < FRAME_LEN; k++) send_byte(f[k]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_hot_duty(input logic [7:0] v);
    drain();
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_frame();
    int r;
    int a;
    int b;
    logic [7:0] mode;
    logic [7:0] fcmd;
    logic [7:0] lamp;
    r = $urandom_range(99);
    mode = (r < 35) ? CH_A : (r < 70) ? CH_M : (r < 85) ? CH_S : 8'($urandom_range(255));
    a = $urandom_range(999);
    b = $urandom_range(999);
    if ($urandom_range(99) < 60 && a > b) begin
      r = a;
      a = b;
      b = r;
    end
    r = $urandom_range(99);
    fcmd = (r < 40) ? CH_F : (r < 70) ? CH_X : 8'($urandom_range(255));
    lamp = ($urandom_range(1) == 1) ? CH_B : 8'($urandom_range(255));
    send_frame(mode, a, b, fcmd, $urandom_range(999), lamp, $urandom_range(99) < 92);
  endtask

  task automatic random_sample();
    int t;
    if ($urandom_range(99) < 70) begin
      t = $urandom_range(1023);
    end else begin
      t = (($urandom_range(1) == 1) ? last_lo : last_up) + $urandom_range(4) - 2;
      if (t < 0) t = 0;
      if (t > 1023) t = 1023;
    end
    send_sample(t);
  endtask

  initial begin
    logic [7:0] duty_plan [6];
    int start;
    int r;

    duty_plan[0] = 8'd255;
    duty_plan[1] = 8'd0;
    duty_plan[2] = 8'($urandom_range(255));
    duty_plan[3] = 8'd1;
    duty_plan[4] = 8'd128;
    duty_plan[5] = 8'($urandom_range(255));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // inverted limits in auto mode, then edge samples
    send_frame(CH_A, 500, 400, CH_X, 0, CH_B, 1'b1);
    send_sample(0);
    send_sample(1023);
    send_sample(450);
    // manual frame with fan speed wrap and lamp on
    send_frame(CH_M, 300, 600, CH_F, 999, CH_B, 1'b1);
    send_sample(0);
    send_sample(1023);
    send_sample(450);
    // status only
    send_frame(CH_S, 0, 999, CH_X, 0, 8'h00, 1'b1);

    garble = 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_hot_duty(duty_plan[p]);
      calm = (p == 2);
      start = word_count;
      while (word_count - start < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 45) begin
          random_frame();
        end else if (r < 80) begin
          random_sample();
        end else begin
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
      end
      calm = 1'b0;
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS thermostat_frame_controller");
    end else begin
      $display("FAIL thermostat_frame_controller");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tfc_pkg.sv
rtl/thermostat_frame_controller.sv
sim/tfc_response_checker.sv
sim/thermostat_frame_controller_tb.sv
